// ===== design/levelset_redistance_step_1d_core_macros.svh =====
// assertion macros for the level-set redistancing core
`ifndef LEVELSET_REDISTANCE_STEP_1D_CORE_MACROS_SVH
`define LEVELSET_REDISTANCE_STEP_1D_CORE_MACROS_SVH

// assert that a condition implies another in the same cycle
`define LRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// assert that a condition implies another in the next cycle
`define LRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== design/lrs_pkg.sv =====
// shared types and constants for the level-set redistancing core
package lrs_pkg;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP   = 1'b1;

    // one task for the back end: a cell with its neighbours
    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] mid;
        logic signed [31:0] right;
        logic               has_left;
        logic               has_right;
        logic               row_end;
    } t_task;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_GRAD,
        ST_TERM,
        ST_TERMH,
        ST_DIV,
        ST_DONE
    } t_state;
endpackage

// ===== design/levelset_redistance_step_1d_core.sv =====
// top level of the 1d level-set redistancing step
//  channel | direction | handshake        | payload
//  input   | in        | i_push / o_full  | level_value, last_cell
//  result  | out       | o_empty / i_pop  | new_level_value, flags, row_end
//  config  | in        | i_cfg_we         | i_cfg_idx, i_cfg_data
// in the back-end sequencer a godunov cell runs DIFF, GRAD, TERM, TERMH, DONE, an
// interface cell DIFF, DIV, DONE (no DIV with a zero denominator), DIV being the
// one-bit-per-cycle divider of h*|phi|/|right-left|; the front end accepts an item
// per cycle while the task queue has room and no second row-end task is pending
// reset is synchronous; it empties the window, queue and result register
// a held result stalls the back end; the queue absorbs input meanwhile until it fills
`include "levelset_redistance_step_1d_core_macros.svh"
module levelset_redistance_step_1d_core
    import lrs_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic signed [31:0] i_level_value,
    input  logic               i_last_cell,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [31:0] o_new_level_value,
    output logic               o_interface_cell,
    output logic               o_zero_denominator,
    output logic               o_row_end,
    input  logic               i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    logic [31:0] r_spacing, r_recip;
    logic  w_tv, w_tr, w_qv, w_qpop, w_rv;
    t_task w_t, w_qt;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= 32'd1 << FRAC_BITS;
            r_recip   <= 32'd1 << FRAC_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPACING: r_spacing <= i_cfg_data;
                CFG_RECIP:   r_recip <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lrs_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_level_value, .i_last_cell,
        .o_task_valid(w_tv), .o_task(w_t), .i_task_ready(w_tr)
    );

    lrs_fifo #(.DEPTH(4)) u_fifo (
        .i_clk, .i_rst_n, .i_wr(w_tv), .i_data(w_t), .o_ready(w_tr),
        .o_valid(w_qv), .o_data(w_qt), .i_rd(w_qpop)
    );

    lrs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_spacing(r_spacing), .i_recip(r_recip),
        .i_task_valid(w_qv), .i_task(w_qt), .o_task_pop(w_qpop),
        .o_res_valid(w_rv), .o_new_level_value, .o_interface_cell,
        .o_zero_denominator, .o_row_end, .i_res_pop(i_pop)
    );

    assign o_empty = !w_rv;

    // checks
    `LRS_ASSERT_IMPLY(a_zd_iface, i_clk, i_rst_n, !o_empty && o_zero_denominator, o_interface_cell)
    `LRS_ASSERT_IMPLY(a_pop_needs_task, i_clk, i_rst_n, w_qpop, w_qv)
    `LRS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !o_empty && !i_pop, !o_empty)
endmodule

// ===== design/lrs_front.sv =====
// front end: window of cells, turns each item into up to two tasks
module lrs_front
    import lrs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic signed [31:0] i_level_value,
    input  logic               i_last_cell,
    output logic               o_task_valid,
    output t_task              o_task,
    input  logic               i_task_ready
);
    logic signed [31:0] r_win0, r_win1, n_win0, n_win1;
    logic [1:0]         r_seen, n_seen;
    // second task of a row end waits here
    logic               r_pend, n_pend;
    t_task              r_pend_task, n_pend_task;
    t_task              w_first;

    assign o_full = r_pend || !i_task_ready;

    // first task built from the window and the new cell
    always_comb begin
        w_first.left      = r_win0;
        w_first.mid       = r_win1;
        w_first.right     = i_level_value;
        w_first.has_left  = (r_seen == 2'd2);
        w_first.has_right = 1'b1;
        w_first.row_end   = 1'b0;
        if (r_seen == 2'd0) begin
            w_first.left      = '0;
            w_first.mid       = i_level_value;
            w_first.right     = '0;
            w_first.has_left  = 1'b0;
            w_first.has_right = 1'b0;
            w_first.row_end   = 1'b1;
        end
    end

    // task output and window update
    always_comb begin
        n_win0 = r_win0;
        n_win1 = r_win1;
        n_seen = r_seen;
        n_pend = r_pend;
        n_pend_task = r_pend_task;
        o_task_valid = 1'b0;
        o_task = w_first;
        if (r_pend) begin
            o_task_valid = 1'b1;
            o_task = r_pend_task;
            if (i_task_ready) n_pend = 1'b0;
        end else if (i_push && i_task_ready) begin
            if (r_seen == 2'd0) begin
                if (i_last_cell) begin
                    o_task_valid = 1'b1;
                end else begin
                    n_win1 = i_level_value;
                    n_seen = 2'd1;
                end
            end else begin
                o_task_valid = 1'b1;
                if (i_last_cell) begin
                    n_pend = 1'b1;
                    n_pend_task.left      = r_win1;
                    n_pend_task.mid       = i_level_value;
                    n_pend_task.right     = '0;
                    n_pend_task.has_left  = 1'b1;
                    n_pend_task.has_right = 1'b0;
                    n_pend_task.row_end   = 1'b1;
                    n_seen = 2'd0;
                end else begin
                    n_win0 = r_win1;
                    n_win1 = i_level_value;
                    n_seen = 2'd2;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_pend <= 1'b0;
            r_win0 <= '0;
            r_win1 <= '0;
        end else begin
            r_seen <= n_seen;
            r_pend <= n_pend;
            r_win0 <= n_win0;
            r_win1 <= n_win1;
        end
        r_pend_task <= n_pend_task;
    end
endmodule

// ===== design/lrs_fifo.sv =====
// small task queue between front and back end
module lrs_fifo
    import lrs_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_task i_data,
    output logic  o_ready,
    output logic  o_valid,
    output t_task o_data,
    input  logic  i_rd
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_task            r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_wr, w_rd;

    assign o_ready = (r_cnt != AW'(0) + (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_wr = i_wr && o_ready;
    assign w_rd = i_rd && o_valid;
    assign o_data = r_mem[r_rp];

    // pointer and count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (w_rd) r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== design/lrs_back.sv =====
// back end: godunov step or subcell update, with a serial divider
module lrs_back
    import lrs_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_spacing,
    input  logic [31:0]        i_recip,
    input  logic               i_task_valid,
    input  t_task              i_task,
    output logic               o_task_pop,
    output logic               o_res_valid,
    output logic signed [31:0] o_new_level_value,
    output logic               o_interface_cell,
    output logic               o_zero_denominator,
    output logic               o_row_end,
    input  logic               i_res_pop
);
    // width of a scaled difference and of the full h*|g| product
    localparam int unsigned DW = 65 - FRAC_BITS;
    localparam int unsigned PW = 32 + DW;
    localparam logic signed [34:0] ONE_Q = 35'sd1 <<< FRAC_BITS;
    localparam logic [36:0] TERM_CAP = 37'd1 << 36;

    t_state r_state, n_state;
    t_task  r_t;
    logic   r_iface;
    logic signed [DW-1:0] r_dm, r_dp;
    logic [DW-1:0] r_g;      // |g|
    logic        r_gneg;
    logic [PW-1:0] r_prod;
    // divider
    logic [63:0] r_num;
    logic [32:0] r_den;
    logic [32:0] r_rem;
    logic [63:0] r_quo;
    logic [6:0]  r_cnt;
    // result register
    logic               r_ov;
    logic signed [31:0] r_ores;
    logic               r_oif, r_ozd, r_oend;

    logic w_sl, w_sr;
    logic signed [32:0] w_dl, w_dr, w_rl;
    logic [32:0] w_ml, w_mr, w_den;
    logic [64:0] w_pl, w_pr;
    logic signed [DW-1:0] w_a, w_b, w_gx;
    logic signed [DW:0] w_g;
    logic [63:0] w_phi;
    logic [PW-1:0] w_psh;
    logic [33:0] w_rem_sh;
    logic [36:0] w_term, w_q;
    logic signed [31:0] w_half;
    logic signed [38:0] w_res;
    logic signed [31:0] w_sat;
    logic        w_done;

    // sign products for the interface test
    always_comb begin
        w_sl = ((i_task.mid == 0) || (i_task.left == 0) ||
                (i_task.mid[31] != i_task.left[31]));
        w_sr = ((i_task.mid == 0) || (i_task.right == 0) ||
                (i_task.mid[31] != i_task.right[31]));
    end

    // one-sided differences
    always_comb begin
        w_dl = 33'(r_t.mid) - 33'(r_t.left);
        w_dr = 33'(r_t.right) - 33'(r_t.mid);
        w_ml = w_dl[32] ? 33'(-w_dl) : 33'(w_dl);
        w_mr = w_dr[32] ? 33'(-w_dr) : 33'(w_dr);
        w_pl = 65'(w_ml) * 65'(i_recip);
        w_pr = 65'(w_mr) * 65'(i_recip);
        w_rl = 33'(r_t.right) - 33'(r_t.left);
        w_den = w_rl[32] ? 33'(-w_rl) : 33'(w_rl);
    end

    // upwind gradient
    always_comb begin
        w_a = '0;
        w_b = '0;
        if (!r_t.mid[31] && r_t.mid != 0) begin
            w_a = (r_dm > 0) ? r_dm : '0;
            w_b = (r_dp < 0) ? -r_dp : '0;
        end else if (r_t.mid[31]) begin
            w_a = (r_dm < 0) ? -r_dm : '0;
            w_b = (r_dp > 0) ? r_dp : '0;
        end
        w_gx = (r_t.mid == 0) ? DW'(ONE_Q) : ((w_a > w_b) ? w_a : w_b);
        w_g = (DW+1)'(w_gx) - (DW+1)'(ONE_Q);
    end

    // upper partial product of h*|g|
    always_comb begin
        w_phi = 64'(i_spacing) * 64'(r_g[DW-1:32]);
    end

    // capped shifted product and final result
    always_comb begin
        w_psh = r_prod >> (FRAC_BITS + 1);
        w_term = (w_psh > PW'(TERM_CAP)) ? TERM_CAP : 37'(w_psh);
        w_q = (r_quo > 64'(TERM_CAP)) ? TERM_CAP : 37'(r_quo);
        w_half = r_t.mid / 2;
        if (r_iface) begin
            w_res = r_t.mid[31] ? 39'(w_half) - 39'(w_q) : 39'(w_half) + 39'(w_q);
        end else if (r_t.mid == 0 || r_g == 0) begin
            w_res = 39'(r_t.mid);
        end else if (r_t.mid[31] != r_gneg) begin
            w_res = 39'(r_t.mid) + 39'(w_term);
        end else begin
            w_res = 39'(r_t.mid) - 39'(w_term);
        end
        if (w_res > 39'sd2147483647) w_sat = 32'sh7fffffff;
        else if (w_res < -39'sd2147483648) w_sat = 32'sh80000000;
        else w_sat = 32'(w_res);
        w_rem_sh = {r_rem, r_num[63]};
        w_done = (r_cnt == 7'd63);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_task_valid) n_state = ST_DIFF;
            ST_DIFF: n_state = r_iface ? ((w_den == 0) ? ST_DONE : ST_DIV) : ST_GRAD;
            ST_GRAD: n_state = ST_TERM;
            ST_TERM: n_state = ST_TERMH;
            ST_TERMH: n_state = ST_DONE;
            ST_DIV:  if (w_done) n_state = ST_DONE;
            ST_DONE: if (!r_ov || i_res_pop) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_task_pop = (r_state == ST_IDLE) && i_task_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && (!r_ov || i_res_pop)) r_ov <= 1'b1;
            else if (i_res_pop) r_ov <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_t <= i_task;
                r_iface <= i_task.has_left && i_task.has_right && (w_sl || w_sr);
                r_quo <= '0;
            end
            ST_DIFF: begin
                r_dm <= !r_t.has_left ? '0 :
                        (w_dl[32] ? -$signed(w_pl[64:FRAC_BITS])
                                  : $signed(w_pl[64:FRAC_BITS]));
                r_dp <= !r_t.has_right ? '0 :
                        (w_dr[32] ? -$signed(w_pr[64:FRAC_BITS])
                                  : $signed(w_pr[64:FRAC_BITS]));
                r_num <= 64'(i_spacing) * 64'(r_t.mid[31] ? -33'(r_t.mid) : 33'(r_t.mid));
                r_den <= w_den;
                r_rem <= '0;
                r_cnt <= '0;
            end
            ST_GRAD: begin
                r_g <= w_g[DW] ? DW'(-w_g) : DW'(w_g);
                r_gneg <= w_g[DW];
            end
            // h*|g| in ST_TERM from the low part of |g|, then in ST_TERMH from the high part
            ST_TERM: r_prod <= PW'(64'(i_spacing) * 64'(r_g[31:0]));
            ST_TERMH: r_prod <= r_prod + (PW'(w_phi) << 32);
            ST_DIV: begin
                if (w_rem_sh >= 34'(r_den)) begin
                    r_rem <= 33'(w_rem_sh - 34'(r_den));
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= 33'(w_rem_sh);
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_num <= {r_num[62:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            ST_DONE: if (!r_ov || i_res_pop) begin
                r_ores <= w_sat;
                r_oif <= r_iface;
                r_ozd <= r_iface && (r_den == 0);
                r_oend <= r_t.row_end;
            end
            default: ;
        endcase
    end

    assign o_res_valid = r_ov;
    assign o_new_level_value = r_ores;
    assign o_interface_cell = r_oif;
    assign o_zero_denominator = r_ozd;
    assign o_row_end = r_oend;
endmodule
